// ----- hw/rtl/bppd_pkg.sv -----
`default_nettype none

package bppd_pkg;

    localparam int PALETTE_ENTRIES = 35;
    localparam int LINE_WORDS      = 40;
    localparam int PIXELS_PER_WORD = 16;
    localparam int COLOR_W         = 12;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    // palette read request from the pixel sequencer
    typedef struct packed {
        logic       en;
        logic [5:0] addr;
        logic       last;
    } rd_req_t;

    // Palette entry for one pixel. Windows are 80 px = 5 words; the color
    // picks the window phase. floor(v / 5) is done as (v * 13) >> 6, exact
    // for v below 64.
    function automatic logic [5:0] pal_index(
        input logic [5:0] col,
        input logic [3:0] pix,
        input logic [1:0] color
    );
        logic [6:0]  v;
        logic [10:0] prod;
        logic [3:0]  q;
        logic [5:0]  idx;
        case (color)
            2'd0:    v = 7'(col) + 7'd5;
            2'd1:    v = 7'(col) + 7'd4 + 7'(pix[3]);
            2'd2:    v = 7'(col) + 7'd2 + 7'(pix[3]);
            default: v = 7'(col) + 7'd2;
        endcase
        prod = 11'(v) * 11'd13;
        q    = prod[9:6];
        case (color)
            2'd0:    idx = {q, 2'b00} - 6'd1;
            2'd1:    idx = {q, 2'b00};
            2'd2:    idx = {q, 2'b01};
            default: idx = {q, 2'b10};
        endcase
        if (idx >= 6'(PALETTE_ENTRIES))
        begin
            idx = 6'(PALETTE_ENTRIES - 1);
        end
        return idx;
    endfunction

    // 4-bit channel to 8 bits: rotate left by one, then replicate
    function automatic logic [7:0] widen(input logic [3:0] n);
        logic [3:0] r;
        r = {n[2:0], n[3]};
        return {r, r};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bppd_in_if.sv -----
`default_nettype none

interface bppd_in_if;
    logic        valid;
    logic        ready;
    logic [0:0]  operation;
    logic [5:0]  palette_slot;
    logic [11:0] palette_word;
    logic [15:0] plane_low;
    logic [15:0] plane_high;
    logic [5:0]  word_column;

    modport source (
        output valid, operation, palette_slot, palette_word,
               plane_low, plane_high, word_column,
        input  ready
    );
    modport sink (
        input  valid, operation, palette_slot, palette_word,
               plane_low, plane_high, word_column,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/bppd_out_if.sv -----
`default_nettype none

interface bppd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;

    modport source (
        output valid, red, green, blue, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/bppd_ram.sv -----
`default_nettype none

module bppd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 35,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read-first on a same-address collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bppd_seq.sv -----
`default_nettype none

module bppd_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [15:0]       plane_low,
    input  wire logic [15:0]       plane_high,
    input  wire logic [5:0]        word_column,
    input  wire logic              adv,
    output logic                   can_take,
    output bppd_pkg::rd_req_t      rd
);

    logic        busy_reg, busy_next;
    logic [3:0]  pix_reg, pix_next;
    logic [15:0] plow_reg, phigh_reg;
    logic [5:0]  col_reg;
    logic        step;
    logic        at_end;
    logic [1:0]  color;

    assign step     = busy_reg && adv;
    assign at_end   = (pix_reg == 4'(bppd_pkg::PIXELS_PER_WORD - 1));
    assign can_take = !busy_reg || (at_end && adv);

    // bit 15 is leftmost: bit index is ~pix
    assign color = {phigh_reg[~pix_reg], plow_reg[~pix_reg]};

    always_comb
    begin
        rd.en   = step;
        rd.addr = bppd_pkg::pal_index(col_reg, pix_reg, color);
        rd.last = at_end;
    end

    always_comb
    begin
        busy_next = busy_reg;
        pix_next  = pix_reg;
        if (step)
        begin
            pix_next = pix_reg + 4'd1;
            if (at_end)
            begin
                busy_next = 1'b0;
            end
        end
        if (start)
        begin
            busy_next = 1'b1;
            pix_next  = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pix_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            pix_reg  <= pix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            plow_reg  <= plane_low;
            phigh_reg <= plane_high;
            col_reg   <= (word_column > 6'(bppd_pkg::LINE_WORDS - 1)) ?
                         6'(bppd_pkg::LINE_WORDS - 1) : word_column;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bitplane_palette_pixel_decoder.sv -----
`default_nettype none

// Bitplane scanline decoder with a line palette that varies along x.
// Channel "items" (valid/ready) carries palette loads and plane word pairs;
// channel "pixels" (valid/ready) returns one RGB888 pixel per beat.
// A load beat writes one 12-bit palette entry (slots 35 and up are dropped)
// and produces nothing. A decode beat produces 16 pixel beats, leftmost
// first, with last_pixel set on the sixteenth.
// The first pixel of a decode beat is valid after the palette RAM read and
// the output register that follow the accepting edge.
// Throughput: one pixel per cycle while the receiver keeps ready high; the
// next beat is taken in the cycle the current word's last palette read is
// issued, so words stream with no gap. Rate is set by the single read port
// of the palette RAM.
// Reset clears all control state and marks every palette entry unwritten;
// unwritten entries read as zero (black) through a per-entry valid bit.
// When the receiver holds ready low the output register holds its beat,
// the in-flight read stalls and the sequencer stops issuing reads; input
// is held off until the current word is finished.

module bitplane_palette_pixel_decoder #(
    parameter int PALETTE_ENTRIES = bppd_pkg::PALETTE_ENTRIES
) (
    input wire logic      clk,
    input wire logic      rst_n,
    bppd_in_if.sink       items,
    bppd_out_if.source    pixels
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam int CW = bppd_pkg::COLOR_W;

    logic               accept;
    logic               is_decode;
    logic               start;
    logic               wr_en;
    logic               can_take;
    logic               adv;
    logic               out_adv;
    bppd_pkg::rd_req_t  rd;
    logic [CW-1:0]      ram_q;
    logic [CW-1:0]      color_word;

    logic [PALETTE_ENTRIES-1:0] vld_reg;

    // read stage: RAM output plus its sideband
    logic s1_valid_reg, s1_valid_next;
    logic s1_last_reg;
    logic s1_vld_reg;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] red_reg, green_reg, blue_reg;
    logic       last_reg;

    assign accept    = items.valid && items.ready;
    assign is_decode = (items.operation == bppd_pkg::OP_DECODE);
    assign start     = accept && is_decode;
    assign wr_en     = accept && !is_decode &&
                       (items.palette_slot < 6'(PALETTE_ENTRIES));

    assign out_adv     = !out_valid_reg || pixels.ready;
    assign adv         = !s1_valid_reg || out_adv;
    assign items.ready = can_take;

    bppd_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .plane_low   (items.plane_low),
        .plane_high  (items.plane_high),
        .word_column (items.word_column),
        .adv         (adv),
        .can_take    (can_take),
        .rd          (rd)
    );

    bppd_ram #(
        .WIDTH (CW),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (items.palette_slot[AW-1:0]),
        .wr_data (items.palette_word),
        .rd_en   (rd.en),
        .rd_addr (rd.addr[AW-1:0]),
        .rd_data (ram_q)
    );

    // entry written flags; sampled before the write, like the RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[items.palette_slot[AW-1:0]] <= 1'b1;
        end
    end

    assign s1_valid_next  = adv ? rd.en : s1_valid_reg;
    assign out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            s1_last_reg <= rd.last;
            s1_vld_reg  <= vld_reg[rd.addr[AW-1:0]];
        end
    end

    assign color_word = s1_vld_reg ? ram_q : '0;

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            red_reg   <= bppd_pkg::widen(color_word[11:8]);
            green_reg <= bppd_pkg::widen(color_word[7:4]);
            blue_reg  <= bppd_pkg::widen(color_word[3:0]);
            last_reg  <= s1_last_reg;
        end
    end

    assign pixels.valid      = out_valid_reg;
    assign pixels.red        = red_reg;
    assign pixels.green      = green_reg;
    assign pixels.blue       = blue_reg;
    assign pixels.last_pixel = last_reg;

endmodule

`default_nettype wire
